### src/tpq_pkg.sv
package tpq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    localparam int ID_W     = 16;
    localparam int VAL_W    = 8;
    localparam int KIND_W   = 2;
    localparam int QSIZE_W  = 5;

    // APB register map
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = '0;
    localparam logic [VAL_W-1:0]     THRESHOLD_RESET = 8'd60;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT   = 2'd0,
        KIND_SERVE    = 2'd1,
        KIND_WITHDRAW = 2'd2,
        KIND_QUERY    = 2'd3
    } t_kind;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [VAL_W-1:0] value;
    } t_slot;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_slot            wdata;
        logic [IDX_W-1:0] raddr;
    } t_store_req;

endpackage

### src/tpq_ifs.sv
interface tpq_req_if import tpq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   entry_id;
    logic [VAL_W-1:0]  entry_value;

    modport source (output valid, kind, entry_id, entry_value, input ready);
    modport sink   (input valid, kind, entry_id, entry_value, output ready);
endinterface

interface tpq_rsp_if import tpq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               ok;
    logic [ID_W-1:0]    result_id;
    logic [VAL_W-1:0]   result_value;
    logic [QSIZE_W-1:0] queue_size;

    modport source (output valid, ok, result_id, result_value, queue_size, input ready);
    modport sink   (input valid, ok, result_id, result_value, queue_size, output ready);
endinterface

### src/tpq_slot_store.sv
module tpq_slot_store import tpq_pkg::*; (
    input  logic       i_clk,
    input  t_store_req i_req,
    output t_slot      o_rd
);

    t_slot r_slots [CAPACITY];
    t_slot r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_slots[i_req.waddr] <= i_req.wdata;
        end
        r_rd <= r_slots[i_req.raddr];
    end

    assign o_rd = r_rd;

endmodule

### src/tpq_seq.sv
module tpq_seq import tpq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [VAL_W-1:0] i_threshold,
    tpq_req_if.sink          i_req,
    tpq_rsp_if.source        o_rsp,
    output t_store_req       o_store,
    input  t_slot            i_rd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT_UP,
        ST_SHIFT_DOWN,
        ST_FINISH
    } t_state;

    t_state             r_state, n_state;
    t_kind              r_kind, n_kind;
    logic [ID_W-1:0]    r_id, n_id;
    logic [VAL_W-1:0]   r_val, n_val;
    logic               r_pri, n_pri;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_pos, n_pos;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_pcount, n_pcount;
    logic               r_ok, n_ok;
    logic [ID_W-1:0]    r_rid, n_rid;
    logic [VAL_W-1:0]   r_rval, n_rval;
    logic               r_ovalid, n_ovalid;
    logic               r_ook, n_ook;
    logic [ID_W-1:0]    r_oid, n_oid;
    logic [VAL_W-1:0]   r_oval, n_oval;
    logic [QSIZE_W-1:0] r_osize, n_osize;

    logic             id_hit;
    logic             at_end;
    logic [CNT_W-1:0] idx_dec;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] raddr_full;
    logic             accept;

    assign id_hit  = (i_rd.id == r_id);
    assign at_end  = (r_idx == r_count);
    assign idx_dec = r_idx - CNT_W'(1);
    assign idx_inc = r_idx + CNT_W'(1);
    assign accept  = i_req.valid && i_req.ready;

    assign i_req.ready        = (r_state == ST_IDLE);
    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.ok           = r_ook;
    assign o_rsp.result_id    = r_oid;
    assign o_rsp.result_value = r_oval;
    assign o_rsp.queue_size   = r_osize;

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_id     = r_id;
        n_val    = r_val;
        n_pri    = r_pri;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_count  = r_count;
        n_pcount = r_pcount;
        n_ok     = r_ok;
        n_rid    = r_rid;
        n_rval   = r_rval;
        n_ovalid = r_ovalid;
        n_ook    = r_ook;
        n_oid    = r_oid;
        n_oval   = r_oval;
        n_osize  = r_osize;

        o_store.we    = 1'b0;
        o_store.waddr = r_idx[IDX_W-1:0];
        o_store.wdata = i_rd;

        // drop the delivered word
        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_kind  = t_kind'(i_req.kind);
                    n_id    = i_req.entry_id;
                    n_val   = i_req.entry_value;
                    n_pri   = (i_req.entry_value >= i_threshold);
                    n_idx   = '0;
                    n_ok    = 1'b0;
                    n_rid   = '0;
                    n_rval  = '0;
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                case (r_kind)
                    KIND_SERVE: begin
                        if (r_count == '0) begin
                            n_state = ST_FINISH;
                        end else begin
                            n_rid   = i_rd.id;
                            n_ok    = 1'b1;
                            n_pos   = '0;
                            n_state = ST_SHIFT_DOWN;
                        end
                    end
                    KIND_INSERT: begin
                        if (at_end) begin
                            if (r_count == CNT_W'(CAPACITY)) begin
                                n_state = ST_FINISH;
                            end else begin
                                n_pos   = r_pri ? r_pcount : r_count;
                                n_idx   = r_count;
                                n_state = ST_SHIFT_UP;
                            end
                        end else if (id_hit) begin
                            n_state = ST_FINISH;
                        end else begin
                            n_idx = idx_inc;
                        end
                    end
                    KIND_WITHDRAW: begin
                        if (at_end) begin
                            n_state = ST_FINISH;
                        end else if (id_hit) begin
                            n_ok    = 1'b1;
                            n_pos   = r_idx;
                            n_state = ST_SHIFT_DOWN;
                        end else begin
                            n_idx = idx_inc;
                        end
                    end
                    KIND_QUERY: begin
                        if (at_end) begin
                            n_state = ST_FINISH;
                        end else if (id_hit) begin
                            n_ok    = 1'b1;
                            n_rval  = i_rd.value;
                            n_state = ST_FINISH;
                        end else begin
                            n_idx = idx_inc;
                        end
                    end
                    default: begin
                        n_state = ST_FINISH;
                    end
                endcase
            end
            ST_SHIFT_UP: begin
                o_store.we = 1'b1;
                if (r_idx == r_pos) begin
                    // place the new entry into the opened slot
                    o_store.wdata.id    = r_id;
                    o_store.wdata.value = r_val;
                    n_count = r_count + CNT_W'(1);
                    if (r_pri) begin
                        n_pcount = r_pcount + CNT_W'(1);
                    end
                    n_ok    = 1'b1;
                    n_state = ST_FINISH;
                end else begin
                    n_idx = idx_dec;
                end
            end
            ST_SHIFT_DOWN: begin
                if (idx_inc < r_count) begin
                    o_store.we = 1'b1;
                    n_idx      = idx_inc;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    if (r_pos < r_pcount) begin
                        n_pcount = r_pcount - CNT_W'(1);
                    end
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid = 1'b1;
                    n_ook    = r_ok;
                    n_oid    = r_rid;
                    n_oval   = r_rval;
                    n_osize  = QSIZE_W'(r_count);
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // address the slot the next state works on; the slot store registers the read data
        case (n_state)
            ST_SHIFT_UP:   raddr_full = n_idx - CNT_W'(1);
            ST_SHIFT_DOWN: raddr_full = n_idx + CNT_W'(1);
            default:       raddr_full = n_idx;
        endcase
        o_store.raddr = raddr_full[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_pcount <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pcount <= n_pcount;
            r_ovalid <= n_ovalid;
        end
        r_kind  <= n_kind;
        r_id    <= n_id;
        r_val   <= n_val;
        r_pri   <= n_pri;
        r_idx   <= n_idx;
        r_pos   <= n_pos;
        r_ok    <= n_ok;
        r_rid   <= n_rid;
        r_rval  <= n_rval;
        r_ook   <= n_ook;
        r_oid   <= n_oid;
        r_oval  <= n_oval;
        r_osize <= n_osize;
    end

endmodule

### src/two_class_priority_queue_core.sv
// Each word passes through an accept, an id search of one slot per cycle that ends at the hit
// or one past the last held slot (a serve skips it), a shift of one slot per cycle that opens or
// closes a gap for an insert or a removal, and a final step that loads the output register.
// One word is in flight at a time; a finished result waits in the output register without
// blocking the next accept, and the next word's last cycle holds until that register is read.
// Reset clears the counts and output valid and sets the threshold to 60; slots are not cleared.
module two_class_priority_queue_core import tpq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tpq_req_if.sink            i_req,
    tpq_rsp_if.source          o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [VAL_W-1:0] r_threshold;
    logic [VAL_W-1:0] n_threshold;
    logic             sel_threshold;
    t_store_req       store_req;
    t_slot            store_rd;

    assign pready        = 1'b1;
    assign sel_threshold = (paddr[PADDR_W-1:2] == REG_THRESHOLD);

    always_comb begin
        n_threshold = r_threshold;
        if (psel && penable && pwrite && pready && sel_threshold) begin
            n_threshold = pwdata[VAL_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_threshold) begin
            prdata = PDATA_W'(r_threshold);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else begin
            r_threshold <= n_threshold;
        end
    end

    tpq_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_threshold (r_threshold),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_store     (store_req),
        .i_rd        (store_rd)
    );

    tpq_slot_store u_store (
        .i_clk (i_clk),
        .i_req (store_req),
        .o_rd  (store_rd)
    );

endmodule

### test/testbench.sv
module testbench;
    import tpq_pkg::*;

    typedef struct packed {
        logic               ok;
        logic [ID_W-1:0]    rid;
        logic [VAL_W-1:0]   rval;
        logic [QSIZE_W-1:0] qsize;
    } t_result;

    // One word of the directed script; want is used only where typed is set.
    typedef struct packed {
        t_kind            kind;
        logic [ID_W-1:0]  id;
        logic [VAL_W-1:0] value;
        logic             typed;
        t_result          want;
    } t_row;

    localparam logic [REG_IDX_W-1:0] REG_SPARE = 1'b1;
    localparam t_result SKIP      = '0;
    localparam int      N_ROWS    = 25;
    localparam int      HOLD_LEN  = 300;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    tpq_req_if req_bus();
    tpq_rsp_if rsp_bus();

    two_class_priority_queue_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the queue: priority entries first, then regular ones.
    t_slot            held[$];
    int               prio_count;
    logic [VAL_W-1:0] threshold;
    t_result          pending[$];
    t_result          oldest;

    int  mismatches;
    int  words_sent;
    int  results_seen;
    int  refused;
    int  by_kind [4];
    int  idle_pct;
    bit  calm;
    bit  want_hold;

    t_row rows [N_ROWS] = '{
        '{KIND_SERVE,    16'h0000, 8'd0,   1'b1, '{1'b0, 16'h0000, 8'h00, 5'd0}},
        '{KIND_WITHDRAW, 16'hBEEF, 8'd0,   1'b1, '{1'b0, 16'h0000, 8'h00, 5'd0}},
        '{KIND_QUERY,    16'hFFFF, 8'd0,   1'b1, '{1'b0, 16'h0000, 8'h00, 5'd0}},
        '{KIND_INSERT,   16'h0000, 8'd0,   1'b1, '{1'b1, 16'h0000, 8'h00, 5'd1}},
        '{KIND_INSERT,   16'hFFFF, 8'd255, 1'b1, '{1'b1, 16'h0000, 8'h00, 5'd2}},
        '{KIND_INSERT,   16'h0000, 8'd77,  1'b1, '{1'b0, 16'h0000, 8'h00, 5'd2}},
        '{KIND_QUERY,    16'hFFFF, 8'd0,   1'b1, '{1'b1, 16'h0000, 8'hFF, 5'd2}},
        '{KIND_INSERT,   16'h003C, 8'd60,  1'b0, SKIP},
        '{KIND_INSERT,   16'h003B, 8'd59,  1'b0, SKIP},
        '{KIND_INSERT,   16'h8000, 8'd200, 1'b0, SKIP},
        '{KIND_INSERT,   16'h0001, 8'd10,  1'b0, SKIP},
        '{KIND_INSERT,   16'h7FFF, 8'd255, 1'b0, SKIP},
        '{KIND_INSERT,   16'hAAAA, 8'd61,  1'b0, SKIP},
        '{KIND_INSERT,   16'h5555, 8'd59,  1'b0, SKIP},
        '{KIND_INSERT,   16'h1000, 8'd128, 1'b0, SKIP},
        '{KIND_INSERT,   16'h0F0F, 8'd1,   1'b0, SKIP},
        '{KIND_INSERT,   16'hF0F0, 8'd254, 1'b0, SKIP},
        '{KIND_INSERT,   16'h00FF, 8'd100, 1'b0, SKIP},
        '{KIND_INSERT,   16'hFF00, 8'd30,  1'b0, SKIP},
        '{KIND_INSERT,   16'h1234, 8'd90,  1'b0, SKIP},
        '{KIND_INSERT,   16'h4321, 8'd45,  1'b0, SKIP},
        '{KIND_INSERT,   16'h2222, 8'd200, 1'b1, '{1'b0, 16'h0000, 8'h00, 5'd16}},
        '{KIND_QUERY,    16'hAAAA, 8'd0,   1'b0, SKIP},
        '{KIND_WITHDRAW, 16'h5555, 8'd0,   1'b0, SKIP},
        '{KIND_SERVE,    16'h0000, 8'd0,   1'b0, SKIP}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        $display("mismatch %s: got 0x%0h, expected 0x%0h (result %0d, t=%0t)",
                 what, got, want, results_seen, $time);
    endtask

    function automatic int find_entry(input logic [ID_W-1:0] id);
        for (int i = 0; i < held.size(); i++) begin
            if (held[i].id == id) return i;
        end
        return -1;
    endfunction

    function automatic void drop_entry(input int pos);
        held.delete(pos);
        if (pos < prio_count) prio_count--;
    endfunction

    function automatic t_result step_queue(input t_kind kind, input logic [ID_W-1:0] id,
                                           input logic [VAL_W-1:0] value);
        t_result r;
        t_slot   slot;
        int      pos;
        r = '0;
        pos = find_entry(id);
        slot.id = id;
        slot.value = value;
        case (kind)
            KIND_INSERT: begin
                if (pos < 0 && held.size() < CAPACITY) begin
                    if (value >= threshold) begin
                        held.insert(prio_count, slot);
                        prio_count++;
                    end else begin
                        held.push_back(slot);
                    end
                    r.ok = 1'b1;
                end
            end
            KIND_SERVE: begin
                if (held.size() != 0) begin
                    r.rid = held[0].id;
                    drop_entry(0);
                    r.ok = 1'b1;
                end
            end
            KIND_WITHDRAW: begin
                if (pos >= 0) begin
                    drop_entry(pos);
                    r.ok = 1'b1;
                end
            end
            default: begin
                if (pos >= 0) begin
                    r.rval = held[pos].value;
                    r.ok = 1'b1;
                end
            end
        endcase
        r.qsize = QSIZE_W'(held.size());
        if (!r.ok) refused++;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input t_kind kind, input logic [ID_W-1:0] id,
                             input logic [VAL_W-1:0] value, input logic typed,
                             input t_result want);
        t_result predicted;
        req_bus.valid       <= 1'b1;
        req_bus.kind        <= kind;
        req_bus.entry_id    <= id;
        req_bus.entry_value <= value;
        do @(posedge i_clk); while (!req_bus.ready);
        predicted = step_queue(kind, id, value);
        pending.push_back(typed ? want : predicted);
        words_sent++;
        by_kind[kind]++;
        @(negedge i_clk);
    endtask

    task automatic maybe_idle();
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        req_bus.valid <= 1'b0;
        do @(negedge i_clk); while (pending.size() != 0);
    endtask

    task automatic apb_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                              input logic [PDATA_W-1:0] data,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        if (wr && idx == REG_THRESHOLD) threshold = data[VAL_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic check_threshold();
        logic [PDATA_W-1:0] rdata;
        apb_access(1'b0, REG_THRESHOLD, '0, rdata);
        if (rdata !== PDATA_W'(threshold))
            flag_mismatch("threshold readback", 32'(rdata), 32'(threshold));
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (held.size() != 0 && r < 45) return held[$urandom_range(0, held.size() - 1)].id;
        // small pool, larger than the queue, so inserts collide and fill it
        if (r < 85) return ID_W'($urandom_range(0, 23) * 2731);
        return ID_W'($urandom());
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        int t;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 5) begin
            t = int'(threshold) + int'($urandom_range(0, 2)) - 1;
            if (t < 0) t = 0;
            if (t > 255) t = 255;
            return VAL_W'(t);
        end
        return VAL_W'($urandom_range(0, 255));
    endfunction

    task automatic run_phase(input logic [VAL_W-1:0] thr, input int ins_pct, input int idle,
                             input int count, input int hold_at, input int pause_at);
        logic [PDATA_W-1:0] unused;
        t_kind              kind;
        int                 r;
        int                 rest;
        drain();
        apb_access(1'b1, REG_THRESHOLD, PDATA_W'(thr), unused);
        check_threshold();
        idle_pct = idle;
        rest = (100 - ins_pct) / 3;
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) want_hold = 1'b1;
            if (n == pause_at) drain();
            r = $urandom_range(0, 99);
            if (r < ins_pct) kind = KIND_INSERT;
            else if (r < ins_pct + rest) kind = KIND_SERVE;
            else if (r < ins_pct + 2 * rest) kind = KIND_WITHDRAW;
            else kind = KIND_QUERY;
            send_word(kind, pick_id(), pick_value(), 1'b0, SKIP);
            maybe_idle();
        end
    endtask

    // Output side: random stalls, plus one long hold-off on request.
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (want_hold) begin
                want_hold = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end else if (!calm && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                stall_left = $urandom_range(1, 5) - 1;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (pending.size() == 0) begin
                flag_mismatch("result with nothing pending", 32'(rsp_bus.result_id), 0);
            end else begin
                oldest = pending.pop_front();
                if (rsp_bus.ok !== oldest.ok)
                    flag_mismatch("ok", 32'(rsp_bus.ok), 32'(oldest.ok));
                if (rsp_bus.result_id !== oldest.rid)
                    flag_mismatch("result_id", 32'(rsp_bus.result_id), 32'(oldest.rid));
                if (rsp_bus.result_value !== oldest.rval)
                    flag_mismatch("result_value", 32'(rsp_bus.result_value),
                                  32'(oldest.rval));
                if (rsp_bus.queue_size !== oldest.qsize)
                    flag_mismatch("queue_size", 32'(rsp_bus.queue_size), 32'(oldest.qsize));
            end
        end
    end

    initial begin
        logic [PDATA_W-1:0] unused;
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        req_bus.valid       <= 1'b0;
        req_bus.kind        <= KIND_INSERT;
        req_bus.entry_id    <= '0;
        req_bus.entry_value <= '0;
        threshold  = THRESHOLD_RESET;
        prio_count = 0;
        by_kind    = '{default: 0};
        idle_pct   = 20;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        check_threshold();
        // unmapped register: the write must leave the threshold alone
        apb_access(1'b1, REG_SPARE, '1, unused);
        check_threshold();

        for (int i = 0; i < N_ROWS; i++) begin
            send_word(rows[i].kind, rows[i].id, rows[i].value, rows[i].typed, rows[i].want);
            maybe_idle();
        end

        run_phase(8'd60,  70, 30, 220, -1, -1);
        run_phase(8'd0,   35, 20, 220, -1, -1);
        run_phase(8'd255, 65, 0,  220, -1, -1);
        run_phase(VAL_W'($urandom_range(1, 254)), 50, 25, 220, 60, -1);
        run_phase(8'd254, 60, 15, 220, -1, 110);
        calm = 1'b1;
        run_phase(8'd128, 50, 0,  250, -1, -1);

        req_bus.valid <= 1'b0;
        for (int c = 0; c < 4000 && pending.size() != 0; c++) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (pending.size() != 0) flag_mismatch("results never returned", pending.size(), 0);

        $display("covered %0d words (%0d insert, %0d serve, %0d withdraw, %0d query),",
                 words_sent, by_kind[KIND_INSERT], by_kind[KIND_SERVE],
                 by_kind[KIND_WITHDRAW], by_kind[KIND_QUERY]);
        $display("%0d refused; checked %0d results over six thresholds incl. 0 and 255, %0d mismatches",
                 refused, results_seen, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
